### hdl/cda_pkg.sv
// Shared constants, codes and calendar helper functions for the date adder.
`default_nettype none

package cda_pkg;

   // Only the low AMOUNT_BITS bits of the amount field take part.
   localparam int AMOUNT_BITS = 16;
   localparam logic [15:0] AMOUNT_MASK = 16'((33'h1 << AMOUNT_BITS) - 33'h1);

   localparam logic [13:0] YEAR_MAX = 14'd9999;

   typedef logic [1:0] action_type;
   localparam action_type ACT_LOAD   = 2'd0;
   localparam action_type ACT_DAYS   = 2'd1;
   localparam action_type ACT_MONTHS = 2'd2;
   localparam action_type ACT_YEARS  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_BAD_DATE = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   // Inverse of 25 modulo 2^14: y is a multiple of 25 exactly when the low
   // 14 bits of y * INV25 are at most DIV25_LIMIT.
   localparam logic [15:0] INV25       = 16'd7209;
   localparam logic [13:0] DIV25_LIMIT = 14'd655;
   // (2^17 + 1) / 3, so that (t * RECIP3) >> 17 is t / 3 for t below 2^17.
   localparam logic [15:0] RECIP3      = 16'd43691;

   function automatic logic is_leap(input logic [13:0] year, input logic [13:0] inv_prod);
      logic div4;
      logic div16;
      logic div25;
      div4  = (year[1:0] == 2'd0);
      div16 = (year[3:0] == 4'd0);
      div25 = (inv_prod <= DIV25_LIMIT);
      // Divisible by 400 is divisible by 16 and by 25.
      return div4 && (div16 || !div25);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### hdl/calendar_date_adder_unit.sv
// Top level of the calendar date adder: sequencer around one shared multiplier.
//
// Channel   Direction  tdata (low bit up)                           tuser
// req_      in         amount, load_year, load_month, load_day      action
// rsp_      out        year_now, month_now, day_now                 status
//
// Load passes through the leap test and the date check; add years first adds
// the amount, and add months first divides by twelve. Add days walks one month
// per cycle and passes through the leap test again for each year crossed.
// The walk loop through the month-length lookup and the shared multiplier used
// for the leap test and the divide by twelve shape these steps.
// Reset is synchronous and returns the date to January 1, 2000.
// One item is in work at a time; a finished result waits in the output
// register, and the next item may be accepted while it waits.
`default_nettype none

module calendar_date_adder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // amount, load_year, load_month, load_day, pad
   input  wire logic [1:0]  req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // year_now, month_now, day_now, pad
   output logic [1:0]       rsp_tuser   // status
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PREP  = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_SPLIT = 8'b0000_1000,
      S_LEAP  = 8'b0001_0000,
      S_CHECK = 8'b0010_0000,
      S_WALK  = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   cda_pkg::action_type  act_ff, act_in;
   logic [15:0]          n_ff, n_in;
   logic [16:0]          y_ff, y_in;
   logic [3:0]           m_ff, m_in;
   logic [4:0]           d_ff, d_in;
   logic [16:0]          tot_ff, tot_in;
   logic [12:0]          q_ff, q_in;
   logic                 leap_ff, leap_in;
   logic [13:0]          cur_year_ff, cur_year_in;
   logic [3:0]           cur_month_ff, cur_month_in;
   logic [4:0]           cur_day_ff, cur_day_in;
   cda_pkg::status_type  status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff, rsp_data_in;
   cda_pkg::status_type  rsp_user_ff, rsp_user_in;

   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] prod;
   logic [4:0]  len;
   logic [4:0]  left;
   logic [16:0] q_times12;

   // The one multiplier serves the leap test and the divide by twelve.
   always_comb begin
      if (state_ff == S_LEAP) begin
         mul_a = {2'b00, y_ff[13:0]};
         mul_b = cda_pkg::INV25;
      end else begin
         mul_a = {1'b0, tot_ff[16:2]};
         mul_b = cda_pkg::RECIP3;
      end
      prod = 32'(mul_a) * 32'(mul_b);
   end

   assign len       = cda_pkg::month_days(m_ff, leap_ff);
   assign left      = len - d_ff;
   assign q_times12 = ({4'b0, q_ff} << 3) + ({4'b0, q_ff} << 2);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      n_in         = n_ff;
      y_in         = y_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      tot_in       = tot_ff;
      q_in         = q_ff;
      leap_in      = leap_ff;
      cur_year_in  = cur_year_ff;
      cur_month_in = cur_month_ff;
      cur_day_in   = cur_day_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in = req_tuser;
               n_in   = req_tdata[15:0] & cda_pkg::AMOUNT_MASK;
               if (req_tuser == cda_pkg::ACT_LOAD) begin
                  y_in     = {3'b000, req_tdata[29:16]};
                  m_in     = req_tdata[33:30];
                  d_in     = req_tdata[38:34];
                  state_in = S_LEAP;
               end else begin
                  y_in     = {3'b000, cur_year_ff};
                  m_in     = cur_month_ff;
                  d_in     = cur_day_ff;
                  state_in = (req_tuser == cda_pkg::ACT_DAYS) ? S_LEAP : S_PREP;
               end
            end
         end
         S_PREP: begin
            if (act_ff == cda_pkg::ACT_YEARS) begin
               y_in     = y_ff + {1'b0, n_ff};
               state_in = S_LEAP;
            end else begin
               tot_in   = {13'b0, m_ff - 4'd1} + {1'b0, n_ff};
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Twelve is four times three: shift, then multiply by 1/3.
            q_in     = prod[29:17];
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            y_in     = y_ff + {4'b0, q_ff};
            m_in     = 4'(tot_ff - q_times12) + 4'd1;
            state_in = S_LEAP;
         end
         S_LEAP: begin
            leap_in  = cda_pkg::is_leap(y_ff[13:0], prod[13:0]);
            state_in = (act_ff == cda_pkg::ACT_DAYS) ? S_WALK : S_CHECK;
         end
         S_CHECK: begin
            state_in = S_FIN;
            if (act_ff == cda_pkg::ACT_LOAD) begin
               if (y_ff[13:0] == 14'd0 || y_ff[13:0] > cda_pkg::YEAR_MAX ||
                   m_ff == 4'd0 || m_ff > 4'd12 || d_ff == 5'd0 || d_ff > len) begin
                  status_in = cda_pkg::ST_BAD_DATE;
               end else begin
                  status_in    = cda_pkg::ST_OK;
                  cur_year_in  = y_ff[13:0];
                  cur_month_in = m_ff;
                  cur_day_in   = d_ff;
               end
            end else if (y_ff > {3'b000, cda_pkg::YEAR_MAX}) begin
               status_in = cda_pkg::ST_OVERFLOW;
            end else begin
               status_in    = cda_pkg::ST_OK;
               cur_year_in  = y_ff[13:0];
               cur_month_in = m_ff;
               cur_day_in   = (d_ff > len) ? len : d_ff;
            end
         end
         S_WALK: begin
            if ({11'b0, left} >= n_ff) begin
               status_in    = cda_pkg::ST_OK;
               cur_year_in  = y_ff[13:0];
               cur_month_in = m_ff;
               cur_day_in   = d_ff + n_ff[4:0];
               state_in     = S_FIN;
            end else begin
               // Step to the first day of the next month.
               n_in = n_ff - {11'b0, left} - 16'd1;
               d_in = 5'd1;
               if (m_ff == 4'd12) begin
                  m_in = 4'd1;
                  y_in = y_ff + 17'd1;
                  if (y_ff[13:0] == cda_pkg::YEAR_MAX) begin
                     status_in = cda_pkg::ST_OVERFLOW;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_LEAP;
                  end
               end else begin
                  m_in = m_ff + 4'd1;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, cur_day_ff, cur_month_ff, cur_year_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_year_ff  <= 14'd2000;
         cur_month_ff <= 4'd1;
         cur_day_ff   <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_year_ff  <= cur_year_in;
         cur_month_ff <= cur_month_in;
         cur_day_ff   <= cur_day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      n_ff        <= n_in;
      y_ff        <= y_in;
      m_ff        <= m_in;
      d_ff        <= d_in;
      tot_ff      <= tot_in;
      q_ff        <= q_in;
      leap_ff     <= leap_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### hdl/cda_checker.sv
// Port-level checks for the calendar date adder, bound to the top level.
`default_nettype none

module cda_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,  // year_now, month_now, day_now, pad
   input wire logic [1:0]  rsp_tuser   // status
);

   // A result that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // Only one item is in work: the input closes right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in work");

   // The kept date always has its year and month in range and a nonzero day, whatever the status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:0] != 14'd0 && rsp_tdata[13:0] <= cda_pkg::YEAR_MAX &&
                     rsp_tdata[17:14] != 4'd0 && rsp_tdata[17:14] <= 4'd12 &&
                     rsp_tdata[22:18] != 5'd0)
      else $error("result date out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == cda_pkg::ST_OK || rsp_tuser == cda_pkg::ST_BAD_DATE ||
                     rsp_tuser == cda_pkg::ST_OVERFLOW)
      else $error("unknown status code");

   // No accepted item, not even an add of zero, has its result valid in the cycle after the accept.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared one cycle after accept");

endmodule

bind calendar_date_adder_unit cda_checker u_cda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### test/calendar_date_adder_unit_tb.sv
// Self-checking testbench for calendar_date_adder_unit: directed and random date actions.
`default_nettype none

module calendar_date_adder_unit_tb;

   typedef struct packed {
      logic [13:0]         year;
      logic [3:0]          month;
      logic [4:0]          day;
      cda_pkg::status_type status;
   } date_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // amount, load_year, load_month, load_day, pad
   logic [1:0]  req_tuser = '0;  // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // year_now, month_now, day_now, pad
   logic [1:0]  rsp_tuser;       // status

   date_result_type expected_dates[$];
   int              mismatch_count = 0;
   int              stall_left = 0;
   bit              no_idle = 1'b0;

   // Calendar state mirrored by the testbench.
   int cal_year = 2000;
   int cal_month = 1;
   int cal_day = 1;

   calendar_date_adder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #40000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int month_length(input int y, input int m);
      int lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      bit leap;
      if (m < 1 || m > 12) return 31;
      leap = (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
      return (m == 2 && leap) ? 29 : lengths[m - 1];
   endfunction

   // Applies one action to the mirrored date and returns the result it must produce.
   function automatic date_result_type advance_calendar(input cda_pkg::action_type act,
                                                        input logic [15:0] amt,
                                                        input logic [13:0] ly,
                                                        input logic [3:0] lm,
                                                        input logic [4:0] ld);
      date_result_type res;
      int n, y, m, d, left, total, year_max;
      bit done;
      n = int'(amt & cda_pkg::AMOUNT_MASK);
      year_max = int'(cda_pkg::YEAR_MAX);
      res.status = cda_pkg::ST_OK;
      case (act)
         cda_pkg::ACT_LOAD: begin
            if (int'(ly) < 1 || int'(ly) > year_max || int'(lm) < 1 || int'(lm) > 12 ||
                int'(ld) < 1 || int'(ld) > month_length(int'(ly), int'(lm))) begin
               res.status = cda_pkg::ST_BAD_DATE;
            end else begin
               cal_year = int'(ly);
               cal_month = int'(lm);
               cal_day = int'(ld);
            end
         end
         cda_pkg::ACT_DAYS: begin
            y = cal_year;
            m = cal_month;
            d = cal_day;
            done = 1'b0;
            while (!done) begin
               left = month_length(y, m) - d;
               if (n <= left) begin
                  done = 1'b1;
               end else begin
                  n = n - (left + 1);
                  d = 1;
                  m = m + 1;
                  if (m > 12) begin
                     m = 1;
                     y = y + 1;
                     if (y > year_max) begin
                        res.status = cda_pkg::ST_OVERFLOW;
                        done = 1'b1;
                     end
                  end
               end
            end
            if (res.status == cda_pkg::ST_OK) begin
               cal_year = y;
               cal_month = m;
               cal_day = d + n;
            end
         end
         cda_pkg::ACT_MONTHS: begin
            total = cal_month - 1 + n;
            y = cal_year + total / 12;
            if (y > year_max) begin
               res.status = cda_pkg::ST_OVERFLOW;
            end else begin
               cal_year = y;
               cal_month = total % 12 + 1;
               if (cal_day > month_length(cal_year, cal_month))
                  cal_day = month_length(cal_year, cal_month);
            end
         end
         default: begin
            y = cal_year + n;
            if (y > year_max) begin
               res.status = cda_pkg::ST_OVERFLOW;
            end else begin
               cal_year = y;
               if (cal_day > month_length(cal_year, cal_month))
                  cal_day = month_length(cal_year, cal_month);
            end
         end
      endcase
      res.year = 14'(cal_year);
      res.month = 4'(cal_month);
      res.day = 5'(cal_day);
      return res;
   endfunction

   // Mostly no gap or a short one, now and then a long one.
   function automatic int idle_length();
      int r;
      if (no_idle) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 50) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   always @(posedge clock) begin : drive_ready
      int len;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         len = idle_length();
         rsp_tready <= (len == 0);
         stall_left <= (len > 0) ? len - 1 : 0;
      end
   end

   always @(posedge clock) begin : check_result
      date_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dates.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d status %0d",
                     $time, rsp_tdata[13:0], rsp_tdata[17:14], rsp_tdata[22:18], rsp_tuser);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_tdata[13:0] !== want.year) begin
               mismatch_count++;
               $display("%0t: year_now expected %0d, actual %0d",
                        $time, want.year, rsp_tdata[13:0]);
            end
            if (rsp_tdata[17:14] !== want.month) begin
               mismatch_count++;
               $display("%0t: month_now expected %0d, actual %0d",
                        $time, want.month, rsp_tdata[17:14]);
            end
            if (rsp_tdata[22:18] !== want.day) begin
               mismatch_count++;
               $display("%0t: day_now expected %0d, actual %0d",
                        $time, want.day, rsp_tdata[22:18]);
            end
            if (rsp_tuser !== want.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d, actual %0d", $time, want.status, rsp_tuser);
            end
         end
      end
   end

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_request(input cda_pkg::action_type act, input logic [15:0] amt,
                               input logic [13:0] ly, input logic [3:0] lm,
                               input logic [4:0] ld);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {1'b0, ld, lm, ly, amt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_dates.push_back(advance_calendar(act, amt, ly, lm, ld));
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      cda_pkg::action_type act;
      logic [15:0] amt;
      logic [13:0] ly;
      logic [3:0]  lm;
      logic [4:0]  ld;
      int r, s;
      // Load fields are random on every item; other actions must ignore them.
      ly = 14'($urandom_range(0, 16383));
      lm = 4'($urandom_range(0, 15));
      ld = 5'($urandom_range(0, 31));
      amt = 16'($urandom_range(0, 65535));
      r = int'($urandom_range(0, 99));
      s = int'($urandom_range(0, 99));
      if (r < 22) begin
         act = cda_pkg::ACT_LOAD;
         if (s < 75) begin
            if (s < 8) ly = 14'($urandom_range(9990, 9999));
            else if (s < 14) ly = 14'($urandom_range(1, 20));
            else ly = 14'($urandom_range(1, 9999));
            lm = 4'($urandom_range(1, 12));
            ld = 5'($urandom_range(1, month_length(int'(ly), int'(lm))));
         end
      end else if (r < 57) begin
         act = cda_pkg::ACT_DAYS;
         // Long day walks are slow, so most amounts stay small.
         if (s < 60) amt = 16'($urandom_range(0, 40));
         else if (s < 90) amt = 16'($urandom_range(41, 800));
         else if (s < 99) amt = 16'($urandom_range(801, 5000));
      end else if (r < 80) begin
         act = cda_pkg::ACT_MONTHS;
         if (s < 70) amt = 16'($urandom_range(0, 30));
         else if (s < 95) amt = 16'($urandom_range(0, 2000));
      end else begin
         act = cda_pkg::ACT_YEARS;
         if (s < 70) amt = 16'($urandom_range(0, 20));
         else if (s < 90) amt = 16'($urandom_range(0, 1000));
      end
      send_request(act, amt, ly, lm, ld);
   endtask

   task automatic test_load();
      send_request(cda_pkg::ACT_DAYS, 16'd0, 14'd0, 4'd0, 5'd0);  // shows the date after reset
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd1, 4'd1, 5'd1);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd9999, 4'd12, 5'd31);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd0, 4'd6, 5'd15);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd10000, 4'd1, 5'd1);
      send_request(cda_pkg::ACT_LOAD, 16'hffff, 14'd16383, 4'd15, 5'd31);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2023, 4'd0, 5'd10);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2023, 4'd13, 5'd10);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2023, 4'd4, 5'd31);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2023, 4'd4, 5'd0);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd1900, 4'd2, 5'd29);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2000, 4'd2, 5'd29);
   endtask

   task automatic test_add_days();
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd1900, 4'd2, 5'd28);
      send_request(cda_pkg::ACT_DAYS, 16'd1, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_DAYS, 16'd0, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd9999, 4'd12, 5'd31);
      send_request(cda_pkg::ACT_DAYS, 16'd1, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd1, 4'd1, 5'd1);
      send_request(cda_pkg::ACT_DAYS, 16'hffff, 14'd0, 4'd0, 5'd0);
   endtask

   task automatic test_add_months();
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2000, 4'd1, 5'd31);
      send_request(cda_pkg::ACT_MONTHS, 16'd1, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_MONTHS, 16'd23, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_MONTHS, 16'hffff, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_MONTHS, 16'hffff, 14'd0, 4'd0, 5'd0);
   endtask

   task automatic test_add_years();
      send_request(cda_pkg::ACT_LOAD, 16'd0, 14'd2000, 4'd2, 5'd29);
      send_request(cda_pkg::ACT_YEARS, 16'd1, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_YEARS, 16'hffff, 14'd0, 4'd0, 5'd0);
      send_request(cda_pkg::ACT_YEARS, 16'd7998, 14'd0, 4'd0, 5'd0);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_request();
   endtask

   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      repeat (count) send_random_request();
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_load();
      test_add_days();
      test_add_months();
      test_add_years();
      test_random_mix(500);
      // The sender holds off here until every result is back.
      wait_all_results();
      test_back_to_back(60);
      test_random_mix(470);
      wait_all_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
